@@ rtl/lap_timer_sequencer_top_defines.svh @@
//------------------------------------------------------------------------------
// Lap timer sequencer: shared assertion macros
// Macros that wrap concurrent assertions on the block's own logic.
//------------------------------------------------------------------------------
`ifndef LAP_TIMER_SEQUENCER_TOP_DEFINES_SVH
`define LAP_TIMER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LTS_ASSERT_SAME(label, clk_sig, rstn_sig, cond, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (cond) |-> (prop)) else $error("lap timer sequencer check failed");

// Next-cycle implication, checked outside reset.
`define LTS_ASSERT_NEXT(label, clk_sig, rstn_sig, cond, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (cond) |=> (prop)) else $error("lap timer sequencer check failed");

`endif

@@ rtl/lts_pkg.sv @@
//------------------------------------------------------------------------------
// Lap timer sequencer package
// Item types, configuration layout, register map and helper functions.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

    // Width of the lap counter and of the stored best lap.
    localparam int LapWidth = 16;

    localparam int CfgAddrWidth = 5;
    localparam int CfgDataWidth = 32;

    typedef enum logic [2:0] {
        REG_RED_HOLD      = 3'd0,
        REG_BLINK_HALF    = 3'd1,
        REG_COUNTDOWN_END = 3'd2,
        REG_START_HORN    = 3'd3,
        REG_INACTIVITY    = 3'd4,
        REG_VICTORY_HORN  = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        TONE_NONE      = 2'd0,
        TONE_COUNTDOWN = 2'd1,
        TONE_GO        = 2'd2
    } tone_t;

    localparam logic [9:0]  RedHoldReset      = 10'd100;
    localparam logic [7:0]  BlinkHalfReset    = 8'd50;
    localparam logic [11:0] CountdownEndReset = 12'd400;
    localparam logic [9:0]  StartHornReset    = 10'd70;
    localparam logic [15:0] InactivityReset   = 16'd3000;
    localparam logic [9:0]  VictoryHornReset  = 10'd70;

    typedef struct packed {
        logic [9:0]  red_hold_ticks;
        logic [7:0]  blink_half_period;
        logic [11:0] countdown_end_ticks;
        logic [9:0]  start_horn_ticks;
        logic [15:0] inactivity_limit;
        logic [9:0]  victory_horn_ticks;
    } cfg_t;

    typedef struct packed {
        logic sensor_level;
        logic start_countdown;
        logic race_enable;
        logic clear_flags;
        logic clear_best;
    } in_item_t;

    typedef struct packed {
        logic        red_lamp;
        logic        green_lamp;
        logic        horn_on;
        logic [1:0]  tone_select;
        logic        lap_valid;
        logic [15:0] lap_time;
        logic [15:0] best_lap;
        logic        countdown_done;
        logic        inactive;
        logic        countdown_active;
        logic [11:0] elapsed_ticks;
        logic [15:0] current_lap;
    } out_item_t;

    // Clamp a lap-width value to the 16-bit display range.
    function automatic logic [15:0] sat16(input logic [LapWidth-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/lts_regs.sv @@
//------------------------------------------------------------------------------
// Lap timer sequencer configuration registers
// APB-style register file holding the six timing settings.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lts_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lts_pkg::CfgAddrWidth-1:0] paddr,
    input  wire logic [lts_pkg::CfgDataWidth-1:0] pwdata,
    output logic      [lts_pkg::CfgDataWidth-1:0] prdata,
    output logic                                  pready,
    output lts_pkg::cfg_t                         cfg
);
    import lts_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = reg_index_t'(paddr[CfgAddrWidth-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_hold_ticks      <= RedHoldReset;
            cfg_reg.blink_half_period   <= BlinkHalfReset;
            cfg_reg.countdown_end_ticks <= CountdownEndReset;
            cfg_reg.start_horn_ticks    <= StartHornReset;
            cfg_reg.inactivity_limit    <= InactivityReset;
            cfg_reg.victory_horn_ticks  <= VictoryHornReset;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_RED_HOLD:      cfg_reg.red_hold_ticks      <= pwdata[9:0];
                REG_BLINK_HALF:    cfg_reg.blink_half_period   <= pwdata[7:0];
                REG_COUNTDOWN_END: cfg_reg.countdown_end_ticks <= pwdata[11:0];
                REG_START_HORN:    cfg_reg.start_horn_ticks    <= pwdata[9:0];
                REG_INACTIVITY:    cfg_reg.inactivity_limit    <= pwdata[15:0];
                REG_VICTORY_HORN:  cfg_reg.victory_horn_ticks  <= pwdata[9:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_RED_HOLD:      prdata = 32'(cfg_reg.red_hold_ticks);
            REG_BLINK_HALF:    prdata = 32'(cfg_reg.blink_half_period);
            REG_COUNTDOWN_END: prdata = 32'(cfg_reg.countdown_end_ticks);
            REG_START_HORN:    prdata = 32'(cfg_reg.start_horn_ticks);
            REG_INACTIVITY:    prdata = 32'(cfg_reg.inactivity_limit);
            REG_VICTORY_HORN:  prdata = 32'(cfg_reg.victory_horn_ticks);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lts_core.sv @@
//------------------------------------------------------------------------------
// Lap timer sequencer core
// Sequencer state and the single-pass update applied for each tick item.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lap_timer_sequencer_top_defines.svh"

module lts_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire lts_pkg::in_item_t  item,
    input  wire lts_pkg::cfg_t      cfg,
    output lts_pkg::out_item_t      result
);
    import lts_pkg::*;

    logic                countdown_running_reg, countdown_running_next;
    logic [11:0]         countdown_count_reg, countdown_count_next;
    logic [7:0]          blink_phase_reg, blink_phase_next;
    logic [LapWidth-1:0] lap_count_reg, lap_count_next;
    logic [LapWidth-1:0] best_time_reg, best_time_next;
    logic                victory_active_reg, victory_active_next;
    logic [9:0]          victory_count_reg, victory_count_next;
    logic                horn_gate_reg, horn_gate_next;
    tone_t               tone_choice_reg, tone_choice_next;
    logic                red_on_reg, red_on_next;
    logic                green_on_reg, green_on_next;
    logic                done_flag_reg, done_flag_next;
    logic                idle_flag_reg, idle_flag_next;
    logic                prev_sensor_reg, prev_sensor_next;

    logic                finished;
    logic                lap_valid;
    logic [LapWidth-1:0] lap_time;

    always_comb
    begin
        countdown_running_next = countdown_running_reg;
        countdown_count_next   = countdown_count_reg;
        blink_phase_next       = blink_phase_reg;
        lap_count_next         = lap_count_reg;
        best_time_next         = best_time_reg;
        victory_active_next    = victory_active_reg;
        victory_count_next     = victory_count_reg;
        horn_gate_next         = horn_gate_reg;
        tone_choice_next       = tone_choice_reg;
        red_on_next            = red_on_reg;
        green_on_next          = green_on_reg;
        done_flag_next         = done_flag_reg;
        idle_flag_next         = idle_flag_reg;
        finished               = 1'b0;
        lap_valid              = 1'b0;
        lap_time               = '0;

        if (item.clear_flags)
        begin
            done_flag_next = 1'b0;
            idle_flag_next = 1'b0;
        end
        if (item.clear_best)
        begin
            best_time_next = '0;
        end

        // A start pulse restarts the countdown from zero with red lit.
        if (item.start_countdown)
        begin
            countdown_running_next = 1'b1;
            countdown_count_next   = '0;
            blink_phase_next       = '0;
            red_on_next            = 1'b1;
        end

        if (countdown_running_next)
        begin
            if (countdown_count_next < 12'(cfg.red_hold_ticks))
            begin
                red_on_next = 1'b1;
            end
            else if (countdown_count_next == 12'(cfg.red_hold_ticks))
            begin
                tone_choice_next = TONE_COUNTDOWN;
                horn_gate_next   = 1'b1;
                blink_phase_next = '0;
            end
            else if (countdown_count_next < cfg.countdown_end_ticks)
            begin
                blink_phase_next = blink_phase_next + 8'd1;
                if (blink_phase_next == cfg.blink_half_period)
                begin
                    blink_phase_next = '0;
                    red_on_next      = !red_on_next;
                    tone_choice_next = TONE_COUNTDOWN;
                    horn_gate_next   = !horn_gate_next;
                end
            end
            else
            begin
                tone_choice_next       = TONE_GO;
                red_on_next            = 1'b0;
                horn_gate_next         = 1'b1;
                done_flag_next         = 1'b1;
                green_on_next          = 1'b1;
                countdown_running_next = 1'b0;
                countdown_count_next   = '0;
                finished               = 1'b1;
            end
            if (!finished)
            begin
                countdown_count_next = countdown_count_next + 12'd1;
            end
        end
        else if (item.race_enable)
        begin
            if (32'(lap_count_next) == 32'(cfg.start_horn_ticks))
            begin
                horn_gate_next = 1'b0;
            end
            if (32'(lap_count_next) < 32'(cfg.inactivity_limit))
            begin
                lap_count_next = lap_count_next + LapWidth'(1);
            end
            else
            begin
                idle_flag_next = 1'b1;
                lap_count_next = '0;
            end
        end

        // A falling sensor edge closes the lap in any mode.
        if (prev_sensor_reg && !item.sensor_level)
        begin
            lap_valid      = 1'b1;
            lap_time       = lap_count_next;
            lap_count_next = '0;
            if ((lap_time < best_time_next) || (best_time_next == '0))
            begin
                best_time_next      = lap_time;
                tone_choice_next    = TONE_GO;
                victory_active_next = 1'b1;
                victory_count_next  = '0;
            end
        end
        prev_sensor_next = item.sensor_level;

        if (victory_active_next)
        begin
            if (victory_count_next < cfg.victory_horn_ticks)
            begin
                horn_gate_next     = 1'b1;
                victory_count_next = victory_count_next + 10'd1;
            end
            else
            begin
                victory_active_next = 1'b0;
                victory_count_next  = '0;
                horn_gate_next      = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.red_lamp         = red_on_next;
        result.green_lamp       = green_on_next;
        result.horn_on          = horn_gate_next;
        result.tone_select      = tone_choice_next;
        result.lap_valid        = lap_valid;
        result.lap_time         = lap_valid ? sat16(lap_time) : 16'd0;
        result.best_lap         = sat16(best_time_next);
        result.countdown_done   = done_flag_next;
        result.inactive         = idle_flag_next;
        result.countdown_active = countdown_running_next;
        result.elapsed_ticks    = countdown_count_next;
        result.current_lap      = sat16(lap_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_running_reg <= 1'b0;
            countdown_count_reg   <= '0;
            blink_phase_reg       <= '0;
            lap_count_reg         <= '0;
            best_time_reg         <= '0;
            victory_active_reg    <= 1'b0;
            victory_count_reg     <= '0;
            horn_gate_reg         <= 1'b0;
            tone_choice_reg       <= TONE_NONE;
            red_on_reg            <= 1'b0;
            green_on_reg          <= 1'b0;
            done_flag_reg         <= 1'b0;
            idle_flag_reg         <= 1'b0;
            prev_sensor_reg       <= 1'b0;
        end
        else if (step)
        begin
            countdown_running_reg <= countdown_running_next;
            countdown_count_reg   <= countdown_count_next;
            blink_phase_reg       <= blink_phase_next;
            lap_count_reg         <= lap_count_next;
            best_time_reg         <= best_time_next;
            victory_active_reg    <= victory_active_next;
            victory_count_reg     <= victory_count_next;
            horn_gate_reg         <= horn_gate_next;
            tone_choice_reg       <= tone_choice_next;
            red_on_reg            <= red_on_next;
            green_on_reg          <= green_on_next;
            done_flag_reg         <= done_flag_next;
            idle_flag_reg         <= idle_flag_next;
            prev_sensor_reg       <= prev_sensor_next;
        end
    end

    // A start pulse always leaves the countdown running after the tick.
    `LTS_ASSERT_NEXT(a_start_runs, clk, rst_n, step && item.start_countdown, countdown_running_reg)
    // Without a tick the lap counter and best lap do not move.
    `LTS_ASSERT_NEXT(a_hold_idle, clk, rst_n, !step, $stable(lap_count_reg) && $stable(best_time_reg))
    // The done flag can only rise on the tick that ends the countdown.
    `LTS_ASSERT_SAME(a_done_at_end, clk, rst_n, $rose(done_flag_reg), $fell(countdown_running_reg))

endmodule

`default_nettype wire

@@ rtl/lap_timer_sequencer_top.sv @@
//------------------------------------------------------------------------------
// Lap timer sequencer top level
// Start lights, horn and lap timing driven by one tick item per centisecond.
//------------------------------------------------------------------------------
// Path: an accepted tick item waits in the input register, and its result is
// offered from the result register; out_stall can hold both registers.
// Throughput: one item per cycle while out_stall is low; the input register,
// single-pass update and result register let a new tick enter every cycle.
// Reset: rst_n clears all sequencer state, both pipeline valids and loads the
// default timing settings; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module lap_timer_sequencer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Tick items in.
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire lts_pkg::in_item_t                in_item,
    // Result items out.
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output lts_pkg::out_item_t                    out_item,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lts_pkg::CfgAddrWidth-1:0] paddr,
    input  wire logic [lts_pkg::CfgDataWidth-1:0] pwdata,
    output logic      [lts_pkg::CfgDataWidth-1:0] prdata,
    output logic                                  pready
);
    import lts_pkg::*;

    // The input register holds one accepted item until the core has applied
    // it; the result register holds the core's answer until it is taken.
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      in_fire;
    logic      step;
    cfg_t      cfg;
    out_item_t core_result;

    // The stored item moves on whenever the result register is empty or is
    // being emptied in this same cycle.
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_fire  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    lts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The core keeps the sequencer state and advances it once per step.
    lts_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; they are qualified by the valids.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg <= in_item;
        end
        if (step)
        begin
            out_item_reg <= core_result;
        end
    end

endmodule

`default_nettype wire
